/* rtl/btpg_pkg.sv */
// Package for the bitmap text pixel generator: sizes, register indexes and operation codes.
package btpg_pkg;

    // Default sizes of the glyph cell and of the text grid.
    localparam int GLYPH_WIDTH_MAX_DEF  = 16;
    localparam int GLYPH_HEIGHT_MAX_DEF = 16;
    localparam int COLUMNS_MAX_DEF      = 64;
    localparam int ROWS_MAX_DEF         = 32;

    // Glyph sheet layout in glyph cells.
    localparam int SHEET_COLS = 16;
    localparam int SHEET_ROWS = 6;

    // Character codes.
    localparam logic [7:0] CHAR_FIRST   = 8'h20;
    localparam logic [7:0] CHAR_LAST    = 8'h7f;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    // Operations.
    localparam logic [1:0] OP_FONT_WRITE = 2'd0;
    localparam logic [1:0] OP_TEXT_CLEAR = 2'd1;
    localparam logic [1:0] OP_APPEND     = 2'd2;
    localparam logic [1:0] OP_PIXEL_READ = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_PIXEL_WIDTH  = 3'd0;
    localparam logic [2:0] REG_BACKGROUND   = 3'd1;
    localparam logic [2:0] REG_FOREGROUND   = 3'd2;
    localparam logic [2:0] REG_ALIGNMENT    = 3'd3;
    localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd4;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd5;

    // Pixel width and alignment codes; the unused pixel width makes every read invalid,
    // and the unused alignment renders as right aligned.
    localparam logic [1:0] PW_8      = 2'd0;
    localparam logic [1:0] PW_16     = 2'd1;
    localparam logic [1:0] PW_32     = 2'd2;
    localparam logic [1:0] PW_NONE   = 2'd3;
    localparam logic [1:0] ALIGN_LEFT      = 2'd0;
    localparam logic [1:0] ALIGN_CENTER    = 2'd1;
    localparam logic [1:0] ALIGN_RIGHT     = 2'd2;
    localparam logic [1:0] ALIGN_RIGHT_ALT = 2'd3;

endpackage

/* rtl/btpg_if.sv */
// Channel interfaces for the input and result transactions.
interface btpg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] font_x;
    logic [6:0] font_y;
    logic       font_set;
    logic [7:0] char_code;
    logic [9:0] pixel_x;
    logic [8:0] pixel_y;

    modport source (output valid, operation, font_x, font_y, font_set, char_code,
                    pixel_x, pixel_y, input ready);
    modport sink   (input valid, operation, font_x, font_y, font_set, char_code,
                    pixel_x, pixel_y, output ready);
endinterface

interface btpg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic        pixel_valid;
    logic        text_overflow;
    logic [10:0] image_width;
    logic [9:0]  image_height;

    modport source (output valid, pixel_value, pixel_valid, text_overflow, image_width,
                    image_height, input ready);
    modport sink   (input valid, pixel_value, pixel_valid, text_overflow, image_width,
                    image_height, output ready);
endinterface

/* rtl/btpg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module btpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/btpg_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module btpg_div #(
    parameter int DW = 10,
    parameter int SW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient,
    output logic [SW-1:0] o_remainder
);
    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_quo;
    logic [SW-1:0]   r_rem;
    logic [SW-1:0]   r_div;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [SW:0]     w_shift;
    logic [SW:0]     w_diff;
    logic            w_fit;

    // One trial subtraction per cycle.
    always_comb begin
        w_shift = {r_rem, r_quo[DW-1]};
        w_diff  = w_shift - {1'b0, r_div};
        w_fit   = (w_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath of the quotient and remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_fit};
            r_rem <= w_fit ? w_diff[SW-1:0] : w_shift[SW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

/* rtl/bitmap_text_pixel_generator_top.sv */
// Top level of the bitmap text pixel generator: sequencer, text state and memories.
//
//  Channel   Direction  Transaction
//  i_in      sink       one operation: font write, text clear, append or pixel read
//  o_res     source     one result per operation: pixel, flags and image size
//  APB       slave      register writes and reads, pready always high
//
// Font writes, clears and appends run through acceptance, an execute step and the result
// load. A pixel read takes two passes of the shared one-bit-per-cycle divider (row from y,
// column from x), two registered RAM reads and the check and address steps. A read that
// misses the image ends after the check, one that lands in a line margin after the row
// pass, and one on a character outside 0x20 to 0x7f after the text RAM read.
// Reset is synchronous and active low; no clearing pass runs, the RAMs are undefined.
// A finished result waits in the output register while the next item is taken;
// the sequencer holds in its final state while an older result is still unread.
module bitmap_text_pixel_generator_top #(
    parameter int GLYPH_WIDTH_MAX  = btpg_pkg::GLYPH_WIDTH_MAX_DEF,
    parameter int GLYPH_HEIGHT_MAX = btpg_pkg::GLYPH_HEIGHT_MAX_DEF,
    parameter int COLUMNS_MAX      = btpg_pkg::COLUMNS_MAX_DEF,
    parameter int ROWS_MAX         = btpg_pkg::ROWS_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btpg_in_if.sink     i_in,
    btpg_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import btpg_pkg::*;

    localparam int SHEET_W  = SHEET_COLS * GLYPH_WIDTH_MAX;
    localparam int SHEET_H  = SHEET_ROWS * GLYPH_HEIGHT_MAX;
    localparam int SHEET_D  = SHEET_W * SHEET_H;
    localparam int SAW      = $clog2(SHEET_D);
    localparam int TEXT_D   = ROWS_MAX * COLUMNS_MAX;
    localparam int TAW      = (TEXT_D > 1) ? $clog2(TEXT_D) : 1;
    localparam int TEXT_DR  = (TEXT_D > 1) ? TEXT_D : 2;
    localparam int GMAX     = (GLYPH_WIDTH_MAX > GLYPH_HEIGHT_MAX) ? GLYPH_WIDTH_MAX
                                                                   : GLYPH_HEIGHT_MAX;
    localparam int SW       = $clog2(GMAX + 1);
    localparam int LW       = $clog2(COLUMNS_MAX + 1);
    localparam int TW       = $clog2(ROWS_MAX + 1);
    localparam int RIW      = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int CIW      = (COLUMNS_MAX > 1) ? $clog2(COLUMNS_MAX) : 1;
    localparam int IW       = LW + SW;
    localparam int HW       = TW + SW;
    localparam int XW       = (IW > 10) ? IW : 10;
    localparam int YW       = (HW > 9) ? HW : 9;
    localparam int SHW      = $clog2(SHEET_H + 1);
    localparam int DW       = 10;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_RCHK = 4'd2;
    localparam logic [3:0] S_DIVY = 4'd3;
    localparam logic [3:0] S_ROW  = 4'd4;
    localparam logic [3:0] S_BND  = 4'd5;
    localparam logic [3:0] S_DIVX = 4'd6;
    localparam logic [3:0] S_TXT  = 4'd7;
    localparam logic [3:0] S_CHR  = 4'd8;
    localparam logic [3:0] S_ADR  = 4'd9;
    localparam logic [3:0] S_GLY  = 4'd10;
    localparam logic [3:0] S_BIT  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    // Configuration registers.
    logic [1:0]  r_pw;
    logic [31:0] r_bg;
    logic [31:0] r_fg;
    logic [1:0]  r_align;
    logic [4:0]  r_gwr;
    logic [4:0]  r_ghr;

    // Text state.
    logic [LW-1:0] r_len [ROWS_MAX];
    logic [TW-1:0] r_total;
    logic [LW-1:0] r_longest;
    logic          r_open;
    logic          r_ovf;

    // Sequencer and item registers.
    logic [3:0]  r_state;
    logic [1:0]  r_op;
    logic [7:0]  r_fx;
    logic [6:0]  r_fy;
    logic        r_fs;
    logic [7:0]  r_ch;
    logic [9:0]  r_px;
    logic [8:0]  r_py;
    logic [31:0] r_val;
    logic        r_vld;
    logic [RIW-1:0] r_row;
    logic [SW-1:0]  r_gy;
    logic [SW-1:0]  r_gx;
    logic [XW-1:0]  r_left;
    logic [XW-1:0]  r_span;
    logic [TAW-1:0] r_taddr;
    logic [SAW-1:0] r_gaddr;
    logic [SHW-1:0] r_rowbase;
    logic [3:0]     r_cx;

    // Output register.
    logic        r_ov;
    logic [31:0] r_o_value;
    logic        r_o_valid;
    logic        r_o_ovf;
    logic [10:0] r_o_width;
    logic [9:0]  r_o_height;

    logic           w_in_take;
    logic           w_res_load;
    logic           w_cfg_wr;
    logic [SW-1:0]  w_gw;
    logic [SW-1:0]  w_gh;
    logic [31:0]    w_mask;
    logic [IW-1:0]  w_img_w;
    logic [HW-1:0]  w_img_h;
    logic [RIW-1:0] w_len_idx;
    logic [LW-1:0]  w_len_rd;
    logic [IW-1:0]  w_span;
    logic [XW-1:0]  w_left;
    logic [XW-1:0]  w_xoff;
    logic           w_div_start;
    logic [DW-1:0]  w_div_dvd;
    logic [SW-1:0]  w_div_dvs;
    logic           w_div_done;
    logic [DW-1:0]  w_div_q;
    logic [SW-1:0]  w_div_r;
    logic           w_opening;
    logic [RIW-1:0] w_arow;
    logic [LW-1:0]  w_alen;
    logic           w_t_we;
    logic [TAW-1:0] w_t_waddr;
    logic [7:0]     w_t_rdata;
    logic           w_g_we;
    logic [SAW-1:0] w_g_waddr;
    logic           w_g_rdata;

    // Clamped glyph size, pixel mask and image size.
    always_comb begin
        if (r_gwr == 5'd0) begin
            w_gw = SW'(1);
        end else if (int'(r_gwr) > GLYPH_WIDTH_MAX) begin
            w_gw = SW'(GLYPH_WIDTH_MAX);
        end else begin
            w_gw = SW'(r_gwr);
        end
        if (r_ghr == 5'd0) begin
            w_gh = SW'(1);
        end else if (int'(r_ghr) > GLYPH_HEIGHT_MAX) begin
            w_gh = SW'(GLYPH_HEIGHT_MAX);
        end else begin
            w_gh = SW'(r_ghr);
        end
        unique case (r_pw)
            PW_8:    w_mask = 32'h0000_00ff;
            PW_16:   w_mask = 32'h0000_ffff;
            default: w_mask = 32'hffff_ffff;
        endcase
        w_img_w = IW'(r_longest) * IW'(w_gw);
        w_img_h = HW'(r_total) * HW'(w_gh);
    end

    // APB port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[4:2])
            REG_PIXEL_WIDTH:  prdata = {30'd0, r_pw};
            REG_BACKGROUND:   prdata = r_bg;
            REG_FOREGROUND:   prdata = r_fg;
            REG_ALIGNMENT:    prdata = {30'd0, r_align};
            REG_GLYPH_WIDTH:  prdata = {27'd0, r_gwr};
            REG_GLYPH_HEIGHT: prdata = {27'd0, r_ghr};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw    <= 2'd0;
            r_bg    <= 32'd0;
            r_fg    <= 32'd255;
            r_align <= 2'd0;
            r_gwr   <= 5'd8;
            r_ghr   <= 5'd8;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_PIXEL_WIDTH:  r_pw    <= pwdata[1:0];
                REG_BACKGROUND:   r_bg    <= pwdata;
                REG_FOREGROUND:   r_fg    <= pwdata;
                REG_ALIGNMENT:    r_align <= pwdata[1:0];
                REG_GLYPH_WIDTH:  r_gwr   <= pwdata[4:0];
                REG_GLYPH_HEIGHT: r_ghr   <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // Append decode: the row being written and its current length.
    always_comb begin
        w_opening = !r_open;
        w_arow    = w_opening ? r_total[RIW-1:0] : RIW'(r_total - 1'b1);
        w_len_idx = (r_state == S_EXEC) ? w_arow : r_row;
        w_len_rd  = r_len[w_len_idx];
        w_alen    = w_opening ? '0 : w_len_rd;
    end

    // Line alignment within the widest line.
    always_comb begin
        w_span = IW'(w_len_rd) * IW'(w_gw);
        unique case (r_align)
            ALIGN_LEFT:   w_left = '0;
            ALIGN_CENTER: w_left = XW'(w_img_w >> 1) - XW'(w_span >> 1);
            default:      w_left = XW'(w_img_w) - XW'(w_span);
        endcase
        w_xoff = XW'(r_px) - r_left;
    end

    // Divider operands.
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = {1'b0, r_py};
        w_div_dvs   = w_gh;
        if (r_state == S_RCHK) begin
            w_div_start = !((r_pw == PW_NONE) || r_ovf || (XW'(r_px) >= XW'(w_img_w))
                            || (YW'(r_py) >= YW'(w_img_h)));
        end else if (r_state == S_BND) begin
            w_div_dvd   = w_xoff[DW-1:0];
            w_div_dvs   = w_gw;
            w_div_start = !((XW'(r_px) < r_left) || (XW'(r_px) >= r_left + r_span));
        end
    end

    btpg_div #(.DW(DW), .SW(SW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q),
        .o_remainder(w_div_r)
    );

    // Memory write ports.
    always_comb begin
        w_t_we    = (r_state == S_EXEC) && (r_op == OP_APPEND) &&
                    !(w_opening && (int'(r_total) >= ROWS_MAX)) &&
                    (r_ch != CHAR_NEWLINE) && (int'(w_alen) < COLUMNS_MAX);
        w_t_waddr = TAW'(int'(w_arow) * COLUMNS_MAX + int'(w_alen));
        w_g_we    = (r_state == S_EXEC) && (r_op == OP_FONT_WRITE) &&
                    (int'(r_fx) < SHEET_W) && (int'(r_fy) < SHEET_H);
        w_g_waddr = SAW'(int'(r_fy) * SHEET_W + int'(r_fx));
    end

    btpg_ram #(.WIDTH(8), .DEPTH(TEXT_DR)) u_text (
        .i_clk  (i_clk),
        .i_we   (w_t_we),
        .i_waddr(w_t_waddr),
        .i_wdata(r_ch),
        .i_raddr(r_taddr),
        .o_rdata(w_t_rdata)
    );

    btpg_ram #(.WIDTH(1), .DEPTH(SHEET_D)) u_sheet (
        .i_clk  (i_clk),
        .i_we   (w_g_we),
        .i_waddr(w_g_waddr),
        .i_wdata(r_fs),
        .i_raddr(r_gaddr),
        .o_rdata(w_g_rdata)
    );

    assign w_in_take   = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_res_load  = (r_state == S_FIN) && (!r_ov || o_res.ready);

    // Sequencer and text state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_longest <= '0;
            r_open    <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_state <= (i_in.operation == OP_PIXEL_READ) ? S_RCHK : S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_TEXT_CLEAR) begin
                        r_total   <= '0;
                        r_longest <= '0;
                        r_open    <= 1'b0;
                        r_ovf     <= 1'b0;
                    end else if (r_op == OP_APPEND) begin
                        if (w_opening && (int'(r_total) >= ROWS_MAX)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            if (w_opening) begin
                                r_total <= r_total + 1'b1;
                            end
                            if (r_ch == CHAR_NEWLINE) begin
                                r_open <= 1'b0;
                            end else begin
                                r_open <= 1'b1;
                                if (int'(w_alen) >= COLUMNS_MAX) begin
                                    r_ovf <= 1'b1;
                                end else if (w_alen + 1'b1 > r_longest) begin
                                    r_longest <= w_alen + 1'b1;
                                end
                            end
                        end
                    end
                    r_state <= S_FIN;
                end
                S_RCHK:  r_state <= w_div_start ? S_DIVY : S_FIN;
                S_DIVY:  r_state <= w_div_done ? S_ROW : S_DIVY;
                S_ROW:   r_state <= S_BND;
                S_BND:   r_state <= w_div_start ? S_DIVX : S_FIN;
                S_DIVX:  r_state <= w_div_done ? S_TXT : S_DIVX;
                S_TXT:   r_state <= S_CHR;
                S_CHR: begin
                    r_state <= (w_t_rdata < CHAR_FIRST || w_t_rdata > CHAR_LAST) ? S_FIN
                                                                                 : S_ADR;
                end
                S_ADR:   r_state <= S_GLY;
                S_GLY:   r_state <= S_BIT;
                S_BIT:   r_state <= S_FIN;
                S_FIN: begin
                    if (w_res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result valid flag: set when a result is loaded, cleared when its transaction is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_res_load) begin
            r_ov <= 1'b1;
        end else if (o_res.valid && o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    // Line length store.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && (r_op == OP_APPEND) &&
            !(w_opening && (int'(r_total) >= ROWS_MAX))) begin
            r_len[w_arow] <= w_t_we ? w_alen + 1'b1 : w_alen;
        end
    end

    // Item payload and read datapath.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op  <= i_in.operation;
            r_fx  <= i_in.font_x;
            r_fy  <= i_in.font_y;
            r_fs  <= i_in.font_set;
            r_ch  <= i_in.char_code;
            r_px  <= i_in.pixel_x;
            r_py  <= i_in.pixel_y;
            r_val <= 32'd0;
            r_vld <= 1'b0;
        end
        if ((r_state == S_DIVY) && w_div_done) begin
            r_row <= w_div_q[RIW-1:0];
            r_gy  <= w_div_r;
        end
        if (r_state == S_ROW) begin
            r_left <= w_left;
            r_span <= XW'(w_span);
        end
        if (r_state == S_BND) begin
            r_val <= r_bg & w_mask;
            r_vld <= 1'b1;
        end
        if ((r_state == S_DIVX) && w_div_done) begin
            r_taddr <= TAW'(int'(r_row) * COLUMNS_MAX + int'(w_div_q[CIW-1:0]));
            r_gx    <= w_div_r;
        end
        if (r_state == S_CHR) begin
            r_rowbase <= SHW'(int'(w_t_rdata[6:4] - 3'd2) * int'(w_gh) + int'(r_gy));
            r_cx      <= w_t_rdata[3:0];
        end
        if (r_state == S_ADR) begin
            r_gaddr <= SAW'(int'(r_rowbase) * SHEET_W + int'(r_cx) * int'(w_gw)
                            + int'(r_gx));
        end
        if ((r_state == S_BIT) && w_g_rdata) begin
            r_val <= r_fg & w_mask;
        end
    end

    // Output register, loaded as the sequencer leaves its final state.
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_o_value  <= r_val;
            r_o_valid  <= r_vld;
            r_o_ovf    <= r_ovf;
            r_o_width  <= 11'(w_img_w);
            r_o_height <= 10'(w_img_h);
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.pixel_value   = r_o_value;
    assign o_res.pixel_valid   = r_o_valid;
    assign o_res.text_overflow = r_o_ovf;
    assign o_res.image_width   = r_o_width;
    assign o_res.image_height  = r_o_height;
endmodule
